// File: sv/joystick_calibrate_and_nav_events_unit_macros.svh
// assertion macros for the joystick calibrate and navigation unit
// used by the top level only; empty bodies under synthesis
`ifndef JOYSTICK_CALIBRATE_AND_NAV_EVENTS_UNIT_MACROS_SVH
`define JOYSTICK_CALIBRATE_AND_NAV_EVENTS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define JCN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define JCN_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JCN_ASSERT(lbl, prop, msg)
`define JCN_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: sv/jcn_pkg.sv
// shared types and constants of the joystick calibrate and navigation unit
// no dependencies
package jcn_pkg;

	localparam int NUM_AXES = 2;
	localparam int AXIS_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

	localparam int LEVEL_W = 16;
	localparam int INDEX_W = 8;
	localparam int PCT_W = 6;
	localparam int ACTION_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 6;

	localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(20);

	// span * percent, then floor divide by 100 through a reciprocal
	localparam int SPAN_W = LEVEL_W + 1;
	localparam int PROD_W = SPAN_W + PCT_W;
	localparam int DIV_SHIFT = 29;
	localparam int RECIP_W = 23;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((2**DIV_SHIFT + 99) / 100);
	localparam int MUL_W = PROD_W + RECIP_W;
	localparam int Q_W = MUL_W - DIV_SHIFT;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CALIBRATE_MODE   = 1'd0,
		REG_DEADBAND_PERCENT = 1'd1
	} cfg_reg_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE     = 4'd0,
		ACT_LEFT     = 4'd1,
		ACT_RIGHT    = 4'd2,
		ACT_UP       = 4'd3,
		ACT_DOWN     = 4'd4,
		ACT_ACTIVATE = 4'd5,
		ACT_CANCEL   = 4'd6,
		ACT_MENU     = 4'd7,
		ACT_CAL_DONE = 4'd8
	} action_t;

	typedef enum logic {
		EVT_AXIS   = 1'b0,
		EVT_BUTTON = 1'b1
	} evt_kind_t;

	typedef struct packed {
		logic                      valid;
		logic [AXIS_W-1:0]         axis;
		logic signed [LEVEL_W-1:0] low;
		logic signed [LEVEL_W-1:0] high;
	} retune_req_t;

	typedef struct packed {
		logic                      valid;
		logic [AXIS_W-1:0]         axis;
		logic signed [LEVEL_W-1:0] lower;
		logic signed [LEVEL_W-1:0] upper;
	} thr_write_t;

endpackage

// File: sv/jcn_if.sv
// valid/ready channels of the joystick calibrate and navigation unit
// depends on jcn_pkg
interface jcn_evt_if;
	logic                               valid;
	logic                               ready;
	logic                               req_type;
	logic [jcn_pkg::INDEX_W-1:0]        index;
	logic signed [jcn_pkg::LEVEL_W-1:0] level;

	modport source (output valid, output req_type, output index, output level, input ready);
	modport sink (input valid, input req_type, input index, input level, output ready);
endinterface

interface jcn_act_if;
	logic                         valid;
	logic                         ready;
	logic [jcn_pkg::ACTION_W-1:0] action;

	modport source (output valid, output action, input ready);
	modport sink (input valid, input action, output ready);
endinterface

// File: sv/jcn_retune.sv
// threshold recompute pipeline: q = floor((high-low)*percent/100),
// lower = low+q, upper = high-q; three register stages; depends on jcn_pkg
module jcn_retune (
	input  logic                       clk,
	input  logic                       arst_n,
	input  jcn_pkg::retune_req_t       req,
	input  logic [jcn_pkg::PCT_W-1:0]  percent,
	output jcn_pkg::thr_write_t        thr_wr,
	output logic                       busy
);

	logic                                v_s1, v_s2, v_s3;
	logic [jcn_pkg::AXIS_W-1:0]          axis_s1, axis_s2, axis_s3;
	logic signed [jcn_pkg::LEVEL_W-1:0]  low_s1, low_s2, low_s3;
	logic signed [jcn_pkg::LEVEL_W-1:0]  high_s1, high_s2, high_s3;
	logic [jcn_pkg::PROD_W-1:0]          prod_s2;
	logic [jcn_pkg::Q_W-1:0]             q_s3;

	logic [jcn_pkg::SPAN_W-1:0] span;
	logic [jcn_pkg::PROD_W-1:0] prod;
	logic [jcn_pkg::MUL_W-1:0]  scaled;

	// high never falls below low, so the span is non-negative
	assign span = {high_s1[jcn_pkg::LEVEL_W-1], high_s1} - {low_s1[jcn_pkg::LEVEL_W-1], low_s1};
	assign prod = jcn_pkg::PROD_W'(span) * jcn_pkg::PROD_W'(percent);
	assign scaled = jcn_pkg::MUL_W'(prod_s2) * jcn_pkg::MUL_W'(jcn_pkg::RECIP_100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		axis_s1 <= req.axis;
		low_s1  <= req.low;
		high_s1 <= req.high;
		axis_s2 <= axis_s1;
		low_s2  <= low_s1;
		high_s2 <= high_s1;
		prod_s2 <= prod;
		axis_s3 <= axis_s2;
		low_s3  <= low_s2;
		high_s3 <= high_s2;
		q_s3    <= scaled[jcn_pkg::MUL_W-1:jcn_pkg::DIV_SHIFT];
	end

	// both results stay within [low, high], so a 16-bit wrap is exact
	assign thr_wr.valid = v_s3;
	assign thr_wr.axis  = axis_s3;
	assign thr_wr.lower = low_s3 + $signed(q_s3[jcn_pkg::LEVEL_W-1:0]);
	assign thr_wr.upper = high_s3 - $signed(q_s3[jcn_pkg::LEVEL_W-1:0]);

	assign busy = v_s1 | v_s2 | v_s3;

endmodule

// File: sv/joystick_calibrate_and_nav_events_unit.sv
// top level of the joystick calibrate and navigation unit
// depends on jcn_pkg, jcn_if, jcn_retune and the assertion macro header
//
// usage:
//   evt carries joystick events (req_type 0 axis, 1 button; index; signed level).
//   act returns exactly one action code per event, in event order.
//   cfg_wen/cfg_index/cfg_data write calibrate_mode (0) and deadband_percent (1);
//   write them only while no event is outstanding.
// output: an event's action is registered on act, via the skid entry if stalled.
// throughput: one event per cycle while evt.ready is high. in calibrate mode a new
//   extreme starts a three-stage threshold recompute (input capture, multiply,
//   reciprocal divide, then a combinational add); in navigate mode evt.ready stays
//   low until that recompute has drained, which only matters on leaving calibrate mode.
// stalls: a result register plus a skid entry sit on act, so one more event is
//   taken while act is stalled; evt.ready drops when the skid entry is full.
// reset: all axis state, thresholds and flags clear, navigate mode, deadband 20.
`include "joystick_calibrate_and_nav_events_unit_macros.svh"

module joystick_calibrate_and_nav_events_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	jcn_evt_if.sink                         evt,
	jcn_act_if.source                       act,
	input  logic                            cfg_wen,
	input  logic [jcn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [jcn_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                        cal_mode_q;
	logic [jcn_pkg::PCT_W-1:0]   pct_q;
	logic                        is_cal_q;

	logic signed [jcn_pkg::LEVEL_W-1:0] axis_low_q  [jcn_pkg::NUM_AXES];
	logic signed [jcn_pkg::LEVEL_W-1:0] axis_high_q [jcn_pkg::NUM_AXES];
	logic signed [jcn_pkg::LEVEL_W-1:0] lower_thr_q [jcn_pkg::NUM_AXES];
	logic signed [jcn_pkg::LEVEL_W-1:0] upper_thr_q [jcn_pkg::NUM_AXES];
	logic signed [jcn_pkg::LEVEL_W-1:0] prev_pos_q  [jcn_pkg::NUM_AXES];
	logic [jcn_pkg::NUM_AXES-1:0]       seen_q;

	logic                out_v_q, skid_v_q;
	jcn_pkg::action_t    out_q, skid_q;

	logic                               in_fire;
	logic                               thr_busy;
	logic [jcn_pkg::AXIS_W-1:0]         ax;
	logic                               ax_ok;
	logic signed [jcn_pkg::LEVEL_W-1:0] lv;
	logic signed [jcn_pkg::LEVEL_W-1:0] cur_low, cur_high, cur_lt, cur_ut, cur_prev;
	logic                               went_low, went_high;
	logic                               low_we, high_we, seen_set, prev_we, cal_set, retune;
	jcn_pkg::action_t                   new_action;
	jcn_pkg::retune_req_t               rt_req;
	jcn_pkg::thr_write_t                thr_wr;

	assign lv       = evt.level;
	assign ax       = evt.index[jcn_pkg::AXIS_W-1:0];
	assign ax_ok    = evt.index < jcn_pkg::INDEX_W'(jcn_pkg::NUM_AXES);
	assign cur_low  = axis_low_q[ax];
	assign cur_high = axis_high_q[ax];
	assign cur_lt   = lower_thr_q[ax];
	assign cur_ut   = upper_thr_q[ax];
	assign cur_prev = prev_pos_q[ax];

	assign went_low  = (lv < cur_lt) && (cur_prev >= cur_lt);
	assign went_high = (lv > cur_ut) && (cur_prev <= cur_ut);

	// navigation reads thresholds, so hold events while a recompute is in flight
	assign evt.ready = !skid_v_q && (cal_mode_q || !thr_busy);
	assign in_fire   = evt.valid && evt.ready;

	always_comb begin
		new_action = jcn_pkg::ACT_NONE;
		low_we     = 1'b0;
		high_we    = 1'b0;
		seen_set   = 1'b0;
		prev_we    = 1'b0;
		cal_set    = 1'b0;
		retune     = 1'b0;
		if (evt.req_type == jcn_pkg::EVT_AXIS) begin
			if (ax_ok) begin
				if (cal_mode_q) begin
					if (!seen_q[ax]) begin
						low_we   = 1'b1;
						high_we  = 1'b1;
						seen_set = 1'b1;
					end else if (lv < cur_low) begin
						low_we = 1'b1;
						retune = 1'b1;
					end else if (lv > cur_high) begin
						high_we = 1'b1;
						retune  = 1'b1;
					end
				end else if (is_cal_q) begin
					prev_we = 1'b1;
					if (evt.index == jcn_pkg::INDEX_W'(0)) begin
						if (went_low)
							new_action = jcn_pkg::ACT_LEFT;
						else if (went_high)
							new_action = jcn_pkg::ACT_RIGHT;
					end else if (evt.index == jcn_pkg::INDEX_W'(1)) begin
						if (went_low)
							new_action = jcn_pkg::ACT_UP;
						else if (went_high)
							new_action = jcn_pkg::ACT_DOWN;
					end
				end
			end
		end else if (cal_mode_q) begin
			if (lv == jcn_pkg::LEVEL_W'(1) && evt.index == jcn_pkg::INDEX_W'(0)) begin
				cal_set    = 1'b1;
				new_action = jcn_pkg::ACT_CAL_DONE;
			end
		end else if (lv == jcn_pkg::LEVEL_W'(0)) begin
			case (evt.index)
				jcn_pkg::INDEX_W'(0): new_action = jcn_pkg::ACT_ACTIVATE;
				jcn_pkg::INDEX_W'(1): new_action = jcn_pkg::ACT_CANCEL;
				jcn_pkg::INDEX_W'(2): new_action = jcn_pkg::ACT_MENU;
				default:              new_action = jcn_pkg::ACT_NONE;
			endcase
		end
	end

	assign rt_req.valid = in_fire && retune;
	assign rt_req.axis  = ax;
	assign rt_req.low   = low_we ? lv : cur_low;
	assign rt_req.high  = high_we ? lv : cur_high;

	jcn_retune u_retune (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (rt_req),
		.percent (pct_q),
		.thr_wr  (thr_wr),
		.busy    (thr_busy)
	);

	// configuration and per-axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_mode_q <= 1'b0;
			pct_q      <= jcn_pkg::PCT_RESET;
			is_cal_q   <= 1'b0;
			seen_q     <= '0;
			for (int a = 0; a < jcn_pkg::NUM_AXES; a++) begin
				axis_low_q[a]  <= '0;
				axis_high_q[a] <= '0;
				lower_thr_q[a] <= '0;
				upper_thr_q[a] <= '0;
				prev_pos_q[a]  <= '0;
			end
		end else begin
			if (in_fire) begin
				if (low_we)
					axis_low_q[ax] <= lv;
				if (high_we)
					axis_high_q[ax] <= lv;
				if (seen_set)
					seen_q[ax] <= 1'b1;
				if (prev_we)
					prev_pos_q[ax] <= lv;
				if (cal_set)
					is_cal_q <= 1'b1;
			end
			if (thr_wr.valid) begin
				lower_thr_q[thr_wr.axis] <= thr_wr.lower;
				upper_thr_q[thr_wr.axis] <= thr_wr.upper;
			end
			if (cfg_wen) begin
				case (cfg_index)
					jcn_pkg::REG_CALIBRATE_MODE: begin
						cal_mode_q <= cfg_data[0];
						if (cfg_data[0])
							seen_q <= '0;
					end
					jcn_pkg::REG_DEADBAND_PERCENT: pct_q <= cfg_data[jcn_pkg::PCT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// result register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || act.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || act.ready)
			out_q <= skid_v_q ? skid_q : new_action;
		else if (in_fire)
			skid_q <= new_action;
	end

	assign act.valid  = out_v_q;
	assign act.action = out_q;

	`JCN_ASSERT_ALWAYS(a_skid_behind_out, (!skid_v_q || out_v_q), "skid entry full while result register empty")
	`JCN_ASSERT(a_skid_on_stall, ($rose(skid_v_q) |-> $past(out_v_q && !act.ready)), "skid filled without a stall")
	`JCN_ASSERT(a_nav_no_hazard, ((in_fire && !cal_mode_q) |-> !thr_busy), "navigate event taken during threshold recompute")
	`JCN_ASSERT(a_done_means_cal, ((out_v_q && out_q == jcn_pkg::ACT_CAL_DONE) |-> is_cal_q), "calibration done reported while not calibrated")

endmodule
